// ----- src/k1bf_pkg.sv -----
`timescale 1ns / 1ps

package k1bf_pkg;

    localparam int TABLE_WORDS = 1042;
    localparam int IDX_W       = 11;
    localparam int P_WORDS     = 18;
    localparam int SBOX_NUM    = 4;
    localparam int SBOX_DEPTH  = 256;
    localparam int ROUNDS      = 16;
    localparam int LAST_FILL   = TABLE_WORDS - 2;
    localparam int PADDR_W     = 3;

    localparam logic REG_GAME_CODE = 1'b0;

    typedef enum logic [1:0] {
        KIND_LOAD  = 2'd0,
        KIND_SETUP = 2'd1,
        KIND_ENC   = 2'd2,
        KIND_DEC   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        SEL_KW12  = 2'd0,
        SEL_KW01  = 2'd1,
        SEL_ZERO  = 2'd2,
        SEL_CHAIN = 2'd3
    } load_sel_t;

    typedef enum logic [1:0] {
        SRC_COPY = 2'd0,
        SRC_LO   = 2'd1,
        SRC_HI   = 2'd2
    } wr_src_t;

    typedef struct packed {
        logic [1:0]       kind;
        logic [IDX_W-1:0] table_index;
        logic [31:0]      table_word;
        logic [1:0]       key_level;
        logic [31:0]      block_low;
        logic [31:0]      block_high;
    } item_t;

    typedef struct packed {
        logic [31:0] out_low;
        logic [31:0] out_high;
        logic        block_valid;
    } result_t;

    typedef struct packed {
        logic             acc;
        logic             init_wr;
        logic             copy_rd;
        logic [IDX_W-1:0] rd_idx;
        logic             tbl_wr;
        logic [IDX_W-1:0] wr_idx;
        wr_src_t          wr_src;
        logic             load_en;
        load_sel_t        load_sel;
        logic             rd;
        logic             upd;
        logic             fin;
        logic             kw_init;
        logic             kw_wb12;
        logic             kw_wb01;
        logic             kw_tweak;
        logic             p_xor;
        logic             out_cap;
        logic             out_blk;
        logic [3:0]       round;
    } cmd_t;

    function automatic logic [31:0] swap_bytes(input logic [31:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

endpackage

// ----- src/key1_blowfish_cipher.sv -----
`timescale 1ns / 1ps

// Channel  | valid         | stall          | payload
// item     | item_valid    | item_stall     | item   (kind, table index/word, level, block)
// result   | result_valid  | result_stall   | result (out_low, out_high, block_valid)
// config   | APB write     | pready = 1     | pwdata -> game_code at byte 0
//
// Encrypt/decrypt per item: accept, 16 rounds of read then update, final, post, done.
// Load: accept, then done. Key setup: table copy, then per pass two key encryptions
// and 521 fill encryptions; two passes, or three for key level 3.
// Reset is asynchronous; the tables hold nothing until loaded and set up.
// One item at a time; a new item is taken while the previous result is still stalled.

module key1_blowfish_cipher
    import k1bf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  item_t              item,
    output logic               result_valid,
    input  logic               result_stall,
    output result_t            result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [31:0] game_code_reg;
    cmd_t        cmd;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_GAME_CODE) ? game_code_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            game_code_reg <= '0;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_GAME_CODE))
        begin
            game_code_reg <= pwdata;
        end
    end

    k1bf_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .cmd          (cmd)
    );

    k1bf_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .item      (item),
        .game_code (game_code_reg),
        .result    (result)
    );

endmodule

// ----- src/k1bf_dpath.sv -----
`timescale 1ns / 1ps

module k1bf_dpath
    import k1bf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    input  item_t       item,
    input  logic [31:0] game_code,
    output result_t     result
);

    logic [31:0] init_mem [TABLE_WORDS];
    logic [31:0] init_rd_reg;
    logic [31:0] sbox_mem [SBOX_NUM][SBOX_DEPTH];
    logic [31:0] sbox_rd_reg [SBOX_NUM];
    logic [31:0] p_reg [P_WORDS];
    logic [31:0] kw_reg [3];
    logic [31:0] a_reg, b_reg, z_reg;
    logic        dec_reg;
    result_t     out_reg;

    logic [4:0]       pidx;
    logic [31:0]      z;
    logic [31:0]      f;
    logic [31:0]      wr_data;
    logic [IDX_W-1:0] off;
    logic [31:0]      fin0, fin1;

    assign pidx = dec_reg ? (5'(P_WORDS - 1) - {1'b0, cmd.round}) : {1'b0, cmd.round};
    assign z    = p_reg[pidx] ^ a_reg;
    assign f    = ((sbox_rd_reg[0] + sbox_rd_reg[1]) ^ sbox_rd_reg[2]) + sbox_rd_reg[3];
    assign off  = cmd.wr_idx - IDX_W'(P_WORDS);
    assign fin0 = dec_reg ? p_reg[1] : p_reg[16];
    assign fin1 = dec_reg ? p_reg[0] : p_reg[17];

    always_comb
    begin
        case (cmd.wr_src)
            SRC_COPY: wr_data = init_rd_reg;
            SRC_LO:   wr_data = b_reg;
            SRC_HI:   wr_data = a_reg;
            default:  wr_data = a_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.init_wr && (item.table_index < IDX_W'(TABLE_WORDS)))
        begin
            init_mem[item.table_index] <= item.table_word;
        end
        if (cmd.copy_rd)
        begin
            init_rd_reg <= init_mem[cmd.rd_idx];
        end
    end

    // S-boxes: one read port each, addressed by one byte of z
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < SBOX_NUM; k++)
        begin
            if (cmd.tbl_wr && (cmd.wr_idx >= IDX_W'(P_WORDS)) && (off[9:8] == 2'(k)))
            begin
                sbox_mem[k][off[7:0]] <= wr_data;
            end
            if (cmd.rd)
            begin
                sbox_rd_reg[k] <= sbox_mem[k][z[31-8*k -: 8]];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.p_xor)
        begin
            for (int i = 0; i < P_WORDS; i++)
            begin
                p_reg[i] <= p_reg[i] ^ swap_bytes(kw_reg[i % 2]);
            end
        end
        if (cmd.tbl_wr && (cmd.wr_idx < IDX_W'(P_WORDS)))
        begin
            p_reg[cmd.wr_idx[4:0]] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kw_reg[0] <= '0;
            kw_reg[1] <= '0;
            kw_reg[2] <= '0;
            dec_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.acc)
            begin
                dec_reg <= (item.kind == KIND_DEC);
            end
            if (cmd.kw_init)
            begin
                kw_reg[0] <= game_code;
                kw_reg[1] <= game_code >> 1;
                kw_reg[2] <= game_code << 1;
            end
            else if (cmd.kw_wb12)
            begin
                kw_reg[1] <= a_reg;
                kw_reg[2] <= b_reg;
            end
            else if (cmd.kw_wb01)
            begin
                kw_reg[0] <= a_reg;
                kw_reg[1] <= b_reg;
            end
            else if (cmd.kw_tweak)
            begin
                kw_reg[1] <= kw_reg[1] << 1;
                kw_reg[2] <= kw_reg[2] >> 1;
            end
        end
    end

    // a holds the second word going into the rounds, b the first
    always_ff @(posedge clk)
    begin
        if (cmd.acc)
        begin
            a_reg <= item.block_high;
            b_reg <= item.block_low;
        end
        else if (cmd.load_en)
        begin
            case (cmd.load_sel)
                SEL_KW12:
                begin
                    a_reg <= kw_reg[2];
                    b_reg <= kw_reg[1];
                end
                SEL_KW01:
                begin
                    a_reg <= kw_reg[1];
                    b_reg <= kw_reg[0];
                end
                SEL_ZERO:
                begin
                    a_reg <= '0;
                    b_reg <= '0;
                end
                default:
                begin
                    a_reg <= b_reg;
                    b_reg <= a_reg;
                end
            endcase
        end
        else if (cmd.upd)
        begin
            a_reg <= b_reg ^ f;
            b_reg <= z_reg;
        end
        else if (cmd.fin)
        begin
            a_reg <= a_reg ^ fin0;
            b_reg <= b_reg ^ fin1;
        end
        if (cmd.rd)
        begin
            z_reg <= z;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_cap)
        begin
            out_reg.out_low     <= cmd.out_blk ? a_reg : '0;
            out_reg.out_high    <= cmd.out_blk ? b_reg : '0;
            out_reg.block_valid <= cmd.out_blk;
        end
    end

    assign result = out_reg;

endmodule

// ----- src/k1bf_ctrl.sv -----
`timescale 1ns / 1ps

module k1bf_ctrl
    import k1bf_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  item_valid,
    output logic  item_stall,
    input  item_t item,
    output logic  result_valid,
    input  logic  result_stall,
    output cmd_t  cmd
);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_COPY  = 11'b000_0000_0010,
        S_LOAD  = 11'b000_0000_0100,
        S_RD    = 11'b000_0000_1000,
        S_UPD   = 11'b000_0001_0000,
        S_FIN   = 11'b000_0010_0000,
        S_POST  = 11'b000_0100_0000,
        S_XOR   = 11'b000_1000_0000,
        S_WR_LO = 11'b001_0000_0000,
        S_WR_HI = 11'b010_0000_0000,
        S_DONE  = 11'b100_0000_0000
    } state_t;

    typedef enum logic [1:0] {
        J_BLOCK = 2'd0,
        J_KW12  = 2'd1,
        J_KW01  = 2'd2,
        J_FILL  = 2'd3
    } job_t;

    state_t           state_reg, state_next;
    job_t             job_reg, job_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [3:0]       round_reg, round_next;
    logic [1:0]       pass_reg, pass_next;
    logic             lvl3_reg, lvl3_next;
    logic             blk_reg, blk_next;
    logic             valid_reg, valid_next;
    logic             out_free;

    assign out_free     = !valid_reg || !result_stall;
    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = valid_reg;

    always_comb
    begin
        state_next = state_reg;
        job_next   = job_reg;
        idx_next   = idx_reg;
        round_next = round_reg;
        pass_next  = pass_reg;
        lvl3_next  = lvl3_reg;
        blk_next   = blk_reg;
        valid_next = valid_reg;
        cmd        = '0;
        cmd.round  = round_reg;
        cmd.rd_idx = idx_reg;
        cmd.wr_idx = idx_reg;
        cmd.out_blk = blk_reg;

        if (valid_reg && !result_stall)
        begin
            valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.acc    = 1'b1;
                    blk_next   = item.kind[1];
                    round_next = '0;
                    unique case (item.kind)
                        KIND_LOAD:
                        begin
                            cmd.init_wr = 1'b1;
                            state_next  = S_DONE;
                        end
                        KIND_SETUP:
                        begin
                            idx_next   = '0;
                            pass_next  = '0;
                            lvl3_next  = (item.key_level == 2'd3);
                            state_next = S_COPY;
                        end
                        default:
                        begin
                            job_next   = J_BLOCK;
                            state_next = S_RD;
                        end
                    endcase
                end
            end
            // read one word ahead, write the word fetched the cycle before
            S_COPY:
            begin
                cmd.copy_rd = (idx_reg < IDX_W'(TABLE_WORDS));
                cmd.tbl_wr  = (idx_reg != '0);
                cmd.wr_idx  = idx_reg - 1'b1;
                cmd.wr_src  = SRC_COPY;
                if (idx_reg == IDX_W'(TABLE_WORDS))
                begin
                    cmd.kw_init = 1'b1;
                    job_next    = J_KW12;
                    state_next  = S_LOAD;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_LOAD:
            begin
                cmd.load_en = 1'b1;
                case (job_reg)
                    J_KW12:  cmd.load_sel = SEL_KW12;
                    J_KW01:  cmd.load_sel = SEL_KW01;
                    default: cmd.load_sel = (idx_reg == '0) ? SEL_ZERO : SEL_CHAIN;
                endcase
                round_next = '0;
                state_next = S_RD;
            end
            S_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_UPD;
            end
            S_UPD:
            begin
                cmd.upd = 1'b1;
                if (round_reg == 4'(ROUNDS - 1))
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    round_next = round_reg + 1'b1;
                    state_next = S_RD;
                end
            end
            S_FIN:
            begin
                cmd.fin    = 1'b1;
                state_next = S_POST;
            end
            S_POST:
            begin
                case (job_reg)
                    J_BLOCK: state_next = S_DONE;
                    J_KW12:
                    begin
                        cmd.kw_wb12 = 1'b1;
                        job_next    = J_KW01;
                        state_next  = S_LOAD;
                    end
                    J_KW01:
                    begin
                        cmd.kw_wb01 = 1'b1;
                        state_next  = S_XOR;
                    end
                    default: state_next = S_WR_LO;
                endcase
            end
            S_XOR:
            begin
                cmd.p_xor  = 1'b1;
                idx_next   = '0;
                job_next   = J_FILL;
                state_next = S_LOAD;
            end
            S_WR_LO:
            begin
                cmd.tbl_wr = 1'b1;
                cmd.wr_src = SRC_LO;
                state_next = S_WR_HI;
            end
            S_WR_HI:
            begin
                cmd.tbl_wr = 1'b1;
                cmd.wr_idx = idx_reg + 1'b1;
                cmd.wr_src = SRC_HI;
                if (idx_reg == IDX_W'(LAST_FILL))
                begin
                    job_next = J_KW12;
                    if (pass_reg == 2'd0)
                    begin
                        pass_next  = 2'd1;
                        state_next = S_LOAD;
                    end
                    else if (pass_reg == 2'd1)
                    begin
                        cmd.kw_tweak = 1'b1;
                        pass_next    = 2'd2;
                        state_next   = lvl3_reg ? S_LOAD : S_DONE;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + 2'd2;
                    state_next = S_LOAD;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.out_cap = 1'b1;
                    valid_next  = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            job_reg   <= J_BLOCK;
            idx_reg   <= '0;
            round_reg <= '0;
            pass_reg  <= '0;
            lvl3_reg  <= 1'b0;
            blk_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            job_reg   <= job_next;
            idx_reg   <= idx_next;
            round_reg <= round_next;
            pass_reg  <= pass_next;
            lvl3_reg  <= lvl3_next;
            blk_reg   <= blk_next;
            valid_reg <= valid_next;
        end
    end

    a_round_start: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOAD) |=> (round_reg == '0))
        else $error("round count not cleared at block start");

    a_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.tbl_wr |-> (cmd.wr_idx < IDX_W'(TABLE_WORDS)))
        else $error("table write index out of range");

    a_fill_even: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WR_LO) |-> !idx_reg[0])
        else $error("fill index odd");

    a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && !out_free) |=> (state_reg == S_DONE))
        else $error("result dropped while output busy");

endmodule
